@@ rtl/core/cbp_pkg.sv @@
`timescale 1ns / 1ps

package cbp_pkg;

    localparam int CODE_W  = 16;
    localparam int COUNT_W = 5;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int SIZE_W  = 6;

    localparam logic [SIZE_W-1:0] WORD_SIZE_RESET = 6'd8;
    localparam logic [SIZE_W-1:0] WORD_SIZE_MAX   = 6'd32;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SIZE_W-1:0] count;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] partial;
        logic [SIZE_W-1:0] limit;
    } step_in_t;

    typedef struct packed {
        logic              emit;
        logic              finish;
        logic [WORD_W-1:0] word;
        logic              last;
        logic [CODE_W-1:0] code;
        logic [SIZE_W-1:0] count;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] partial;
    } step_out_t;

    function automatic logic [WORD_W-1:0] low_mask(input logic [SIZE_W-1:0] n);
        logic [WORD_W-1:0] m;
        begin
            if (n >= SIZE_W'(WORD_W))
            begin
                m = '1;
            end
            else
            begin
                m = (WORD_W'(1) << n[POS_W-1:0]) - WORD_W'(1);
            end
            return m;
        end
    endfunction

endpackage

@@ rtl/core/cbp_step.sv @@
`timescale 1ns / 1ps

// One packing step: fills the current word as far as the held code allows and
// reports whether a word completes, keeping the leftover bits for the next step.
module cbp_step
    import cbp_pkg::*;
(
    input  step_in_t  step_in,
    output step_out_t step_out
);

    logic [SIZE_W-1:0] need;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] limit_min;
    logic [WORD_W-1:0] code_ext;
    logic [WORD_W-1:0] fill_bits;
    logic [WORD_W-1:0] all_bits;
    logic [WORD_W-1:0] left_ext;
    logic [WORD_W-1:0] left_bits;

    always_comb
    begin
        // A position at or past the limit completes the word with one more bit.
        if (SIZE_W'(step_in.pos) < step_in.limit)
        begin
            need = step_in.limit - SIZE_W'(step_in.pos);
        end
        else
        begin
            need = SIZE_W'(1);
        end

        limit_min = (step_in.limit == '0) ? SIZE_W'(1) : step_in.limit;
        code_ext  = WORD_W'(step_in.code);
        fill_bits = (code_ext & low_mask(need)) << step_in.pos;
        all_bits  = (code_ext & low_mask(step_in.count)) << step_in.pos;
        rem       = step_in.count - need;
        left_ext  = code_ext >> need;
        left_bits = left_ext & low_mask(rem);

        step_out = '0;
        step_out.word = step_in.partial | fill_bits;

        if (step_in.count >= need)
        begin
            step_out.emit  = 1'b1;
            step_out.last  = (rem < limit_min);
            step_out.finish = step_out.last;
            step_out.code  = left_ext[CODE_W-1:0];
            step_out.count = rem;
            if (step_out.last)
            begin
                step_out.partial = left_bits;
                step_out.pos     = rem[POS_W-1:0];
            end
            else
            begin
                step_out.partial = '0;
                step_out.pos     = '0;
            end
        end
        else
        begin
            step_out.emit    = 1'b0;
            step_out.last    = 1'b0;
            step_out.finish  = 1'b1;
            step_out.code    = step_in.code;
            step_out.count   = '0;
            step_out.partial = step_in.partial | all_bits;
            step_out.pos     = POS_W'(SIZE_W'(step_in.pos) + step_in.count);
        end
    end

endmodule

@@ rtl/core/channel_bit_packer.sv @@
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// ------   -------------------  -------------------------------
// in       in_valid / in_stall  code_value[15:0], bit_count[4:0]
// out      out_valid/out_stall  channel_word[31:0], last_word
// cfg      cfg_we               cfg_wdata[5:0] (word size)
//
// A code is held in an input register and packed from there. With the output
// free, a code completing at most one word leaves as it is packed, so such
// codes are taken back to back; one completing several stays until each word
// is loaded into the output register. Reset clears the partial word and its
// bit position and sets the word size to 8. While out_stall holds a word that
// waits, a code needing to emit holds in the input register and stalls input.
module channel_bit_packer
    import cbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CODE_W-1:0]  code_value,
    input  logic [COUNT_W-1:0] bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WORD_W-1:0]  channel_word,
    output logic               last_word
);

    localparam logic [SIZE_W-1:0] MAX_COUNT = SIZE_W'(MAX_CODE_BITS);

    logic [SIZE_W-1:0] size_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [SIZE_W-1:0] count_reg;
    logic [SIZE_W-1:0] count_next;
    logic [WORD_W-1:0] partial_reg;
    logic [WORD_W-1:0] partial_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;

    logic [SIZE_W-1:0] count_sat;
    logic              out_free;
    logic              advance;
    logic              item_done;
    logic              in_accept;
    step_in_t          step_in;
    step_out_t         step_out;

    assign step_in.code    = code_reg;
    assign step_in.count   = count_reg;
    assign step_in.pos     = pos_reg;
    assign step_in.partial = partial_reg;
    assign step_in.limit   = (size_reg > WORD_SIZE_MAX) ? WORD_SIZE_MAX : size_reg;

    cbp_step u_step
    (
        .step_in  (step_in),
        .step_out (step_out)
    );

    assign count_sat = (SIZE_W'(bit_count) > MAX_COUNT) ? MAX_COUNT : SIZE_W'(bit_count);
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = item_valid_reg && (!step_out.emit || out_free);
    assign item_done = advance && step_out.finish;
    assign in_stall  = item_valid_reg && !item_done;
    assign in_accept = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign channel_word = word_reg;
    assign last_word    = last_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        code_next       = code_reg;
        count_next      = count_reg;
        partial_next    = partial_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (advance)
        begin
            code_next    = step_out.code;
            count_next   = step_out.count;
            partial_next = step_out.partial;
            pos_next     = step_out.pos;
            if (step_out.emit)
            begin
                out_valid_next = 1'b1;
            end
        end

        if (item_done)
        begin
            item_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            item_valid_next = 1'b1;
            code_next       = code_value;
            count_next      = count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= WORD_SIZE_RESET;
            item_valid_reg <= 1'b0;
            partial_reg    <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            item_valid_reg <= item_valid_next;
            partial_reg    <= partial_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        count_reg <= count_next;
        if (advance && step_out.emit)
        begin
            word_reg <= step_out.word;
            last_reg <= step_out.last;
        end
    end

    // The partial word never holds bits at or above the bit position.
    a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_reg >> pos_reg) == '0)
        else $error("partial word has bits beyond the bit position");

    // A held code's bit count never exceeds the saturation limit MAX_COUNT.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (count_reg <= MAX_COUNT))
        else $error("held bit count above the limit");

    // A code blocked on a full, stalled output keeps its state.
    a_blocked_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && step_out.emit && out_valid_reg && out_stall)
        |=> ($stable(code_reg) && $stable(count_reg) && $stable(pos_reg)
             && $stable(partial_reg) && item_valid_reg))
        else $error("blocked code changed state");

    // Output loads only from a held code.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !$past(out_valid_reg && out_stall))
        |-> $past(item_valid_reg))
        else $error("output word without a held code");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import cbp_pkg::*;
();

    localparam int MAX_BITS      = 16;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } channel_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SIZE_W-1:0]  cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [CODE_W-1:0]  code_value;
    logic [COUNT_W-1:0] bit_count;
    logic               out_valid;
    logic               out_stall;
    logic [WORD_W-1:0]  channel_word;
    logic               last_word;

    channel_word_t      pending_words[$];
    logic [SIZE_W-1:0]  size_reg;
    logic [WORD_W-1:0]  fill_word;
    logic [POS_W-1:0]   fill_pos;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_cycles;
    int error_count;

    channel_bit_packer #(
        .MAX_CODE_BITS(MAX_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_value  (code_value),
        .bit_count   (bit_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_word(channel_word),
        .last_word   (last_word)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Packs one code into the local copy of the word state and queues every
    // word that it completes.
    task automatic predict_code(input logic [CODE_W-1:0] code, input logic [COUNT_W-1:0] count);
        int            nbits;
        int            limit;
        int            next_pos;
        int            emitted;
        channel_word_t w;
        begin
            nbits   = (count > MAX_BITS) ? MAX_BITS : int'(count);
            limit   = (size_reg > WORD_SIZE_MAX) ? int'(WORD_SIZE_MAX) : int'(size_reg);
            emitted = 0;
            for (int i = 0; i < nbits; i++)
            begin
                if (fill_pos == '0)
                begin
                    fill_word = {{(WORD_W-1){1'b0}}, code[i]};
                end
                else
                begin
                    fill_word[fill_pos] = fill_word[fill_pos] | code[i];
                end
                next_pos = int'(fill_pos) + 1;
                if (next_pos >= limit)
                begin
                    w.word = fill_word;
                    w.last = 1'b0;
                    pending_words.push_back(w);
                    emitted++;
                    fill_word = '0;
                    next_pos  = 0;
                end
                fill_pos = next_pos[POS_W-1:0];
            end
            if (emitted > 0)
            begin
                pending_words[$].last = 1'b1;
            end
        end
    endtask

    task automatic offer_code(input logic [CODE_W-1:0] code, input logic [COUNT_W-1:0] count);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            @(negedge clk);
            in_valid   = 1'b1;
            code_value = code;
            bit_count  = count;
            do
            begin
                @(posedge clk);
            end
            while (in_stall);
            predict_code(code, count);
        end
    endtask

    task automatic drain;
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (pending_words.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_word_size(input logic [SIZE_W-1:0] value);
        begin
            drain();
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_wdata = value;
            @(negedge clk);
            cfg_we   = 1'b0;
            size_reg = value;
        end
    endtask

    task automatic random_code;
        int                 r;
        logic [COUNT_W-1:0] count;
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                count = '0;
            end
            else if (r < 14)
            begin
                count = COUNT_W'($urandom_range(31, MAX_BITS + 1));
            end
            else
            begin
                count = COUNT_W'($urandom_range(MAX_BITS, 1));
            end
            offer_code(CODE_W'($urandom_range(16'hFFFF, 0)), count);
        end
    endtask

    task automatic test_reset_size;
        begin
            offer_code(16'hFFFF, 5'd16);
            offer_code(16'h0000, 5'd16);
            offer_code(16'hA5A5, 5'd0);
            offer_code(16'h1234, 5'd5);
            offer_code(16'hFFFF, 5'd31);
            offer_code(16'h8001, 5'd17);
            offer_code(16'h8001, 5'd16);
            drain();
        end
    endtask

    task automatic test_size_extremes;
        begin
            set_word_size(6'd1);
            offer_code(16'hFFFF, 5'd16);
            offer_code(16'h5555, 5'd16);
            set_word_size(6'd32);
            offer_code(16'hBEEF, 5'd16);
            offer_code(16'hCAFE, 5'd16);
            offer_code(16'h7FFF, 5'd3);
            set_word_size(6'd0);
            offer_code(16'hA5A5, 5'd3);
            set_word_size(6'd63);
            offer_code(16'h0F0F, 5'd16);
            offer_code(16'hF0F0, 5'd16);
            offer_code(16'hFFFF, 5'd16);
            drain();
        end
    endtask

    task automatic test_size_lowered;
        begin
            set_word_size(6'd32);
            offer_code(16'hFFFF, 5'd16);
            offer_code(16'h000F, 5'd4);
            set_word_size(6'd8);
            offer_code(16'h0001, 5'd1);
            offer_code(16'h00FF, 5'd8);
            drain();
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [SIZE_W-1:0] size_pick;
        begin
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0: size_pick = SIZE_W'($urandom_range(31, 2));
                    1:
                    begin
                        case ($urandom_range(3))
                            0: size_pick = 6'd0;
                            1: size_pick = 6'd1;
                            2: size_pick = 6'd32;
                            default: size_pick = 6'd63;
                        endcase
                    end
                    2: size_pick = SIZE_W'($urandom_range(32, 1));
                    default: size_pick = SIZE_W'($urandom_range(63, 0));
                endcase
                set_word_size(size_pick);
                for (int k = 0; k < 32; k++)
                begin
                    random_code();
                end
            end
            drain();
        end
    endtask

    task automatic test_output_backpressure;
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            set_word_size(6'd4);
            @(posedge clk);
            hold_left = HOLD_CYCLES;
            for (int k = 0; k < 30; k++)
            begin
                offer_code(CODE_W'($urandom_range(16'hFFFF, 0)),
                           COUNT_W'($urandom_range(MAX_BITS, 8)));
            end
            drain();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        channel_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual channel_word %h last_word %b",
                         $time, channel_word, last_word);
                error_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (channel_word !== w.word)
                begin
                    $display("%0t: channel_word mismatch, expected %h, actual %h",
                             $time, w.word, channel_word);
                    error_count++;
                end
                if (last_word !== w.last)
                begin
                    $display("%0t: last_word mismatch, expected %b, actual %b",
                             $time, w.last, last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        code_value    = '0;
        bit_count     = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        idle_cycles   = 0;
        error_count   = 0;
        size_reg      = WORD_SIZE_RESET;
        fill_word     = '0;
        fill_pos      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_size();
        test_size_extremes();
        test_size_lowered();
        test_random_traffic(30, 51);
        test_random_traffic(51, 30);
        test_random_traffic(0, 0);
        test_output_backpressure();
        drain();

        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
